/* sv/bcpe_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the binomial table for the bezier point evaluator
// no dependencies

package bcpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int PIDX_W  = 4;   // width of the point_index field
  localparam int CNT_W   = 5;   // width of the point_count register
  localparam int PARAM_W = 17;  // t in q0.16, one included
  localparam int FRAC16  = 16;
  localparam int FRAC32  = 32;

  // powers and weights in q0.32, 2^32 included
  localparam int POW_W  = FRAC32 + 1;
  localparam int HALF_W = POW_W - FRAC16;
  // largest binomial of degree MAX_POINTS-1 (6435 for sixteen points)
  localparam int COMB_W = 13;

  // shared multiplier: signed operands wide enough for every unsigned use
  localparam int MUL_A_W = POW_W + 1;
  localparam int MUL_B_W = PARAM_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // low partial product of a power times a power
  localparam int PLO_W = POW_W + FRAC16;
  localparam int HSUM_W = PLO_W + 1;

  // weights sum to at most 2^32, so the sum of weighted points stays small
  localparam int ACC_W = FRAC32 + COORD_BITS + 2;
  localparam int QUO_W = ACC_W - FRAC32;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(1) << FRAC16;
  localparam logic [POW_W-1:0]   ONE_Q32 = POW_W'(1) << FRAC32;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW,
    ST_MLO,
    ST_MHI,
    ST_MW,
    ST_MX,
    ST_MY,
    ST_MT,
    ST_FIN
  } state_e;

  typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][COMB_W-1:0] binom_tab_t;

  // pascal triangle, rows are the degree
  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < MAX_POINTS; n++) begin
      tab[n][0] = COMB_W'(1);
      for (int k = 1; k <= n; k++) begin
        tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  // drop 32 fraction bits toward zero, then clamp to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] finish_coord(
    input logic signed [ACC_W-1:0] s
  );
    logic [ACC_W-1:0]          bias;
    logic [ACC_W-1:0]          adj;
    logic signed [QUO_W-1:0]   q;
    logic signed [QUO_W-1:0]   sat_hi;
    logic signed [QUO_W-1:0]   sat_lo;
    logic signed [COORD_BITS-1:0] r;
    bias   = {{QUO_W{1'b0}}, {FRAC32{1'b1}}};
    adj    = s[ACC_W-1] ? (ACC_W'(s) + bias) : ACC_W'(s);
    q      = signed'(adj[ACC_W-1:FRAC32]);
    sat_hi = QUO_W'((2 ** (COORD_BITS - 1)) - 1);
    sat_lo = -sat_hi - QUO_W'(1);
    if (q > sat_hi) begin
      r = sat_hi[COORD_BITS-1:0];
    end else if (q < sat_lo) begin
      r = sat_lo[COORD_BITS-1:0];
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/bcpe_if.sv */
`timescale 1ns / 1ps
// request and result channels of the bezier point evaluator
// depends on bcpe_pkg

interface bcpe_in_if;
  import bcpe_pkg::*;

  logic                         valid;
  logic                         ready;
  cmd_e                         cmd;
  logic [PIDX_W-1:0]            point_index;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [PARAM_W-1:0]           curve_param;

  modport source (
    output valid, cmd, point_index, point_x, point_y, curve_param,
    input  ready
  );
  modport sink (
    input  valid, cmd, point_index, point_x, point_y, curve_param,
    output ready
  );
endinterface

interface bcpe_out_if;
  import bcpe_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] curve_x;
  logic signed [COORD_BITS-1:0] curve_y;

  modport source (
    output valid, curve_x, curve_y,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y,
    output ready
  );
endinterface

/* sv/bezier_curve_point_eval.sv */
`timescale 1ns / 1ps
// bezier curve point evaluator in bernstein form, one shared multiplier
// depends on bcpe_pkg and the channel interfaces in bcpe_if.sv
//
// usage
//   in_if carries requests: cmd load writes one control point into the slot
//   point_index, cmd eval asks for the curve point at t = curve_param (q0.16)
//   out_if carries one result (curve_x, curve_y) per eval request, none per load
//   cfg_we_i / cfg_wdata_i write point_count while the block is idle
// timing
//   a load request is taken while the block is idle and ready stays high after it
//   an eval request over c points runs c-1 power steps, five multiplier
//   passes per point and one t step between points, then the finish state
//   (for c = 0 only the finish state), from which the result enters the
//   output register, and ready returns with it
//   the 34x18 multiplier is the only multiplier and is shared by every step
// reset
//   state, point_count and the output valid clear, the point table is not
//   cleared and a slot must be loaded before an eval reads it
// stalls
//   the result waits in the output register; a finished evaluation holds in
//   its last state until that register is free, then the block is idle again

module bezier_curve_point_eval
  import bcpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bcpe_in_if.sink          in_if,
  bcpe_out_if.source       out_if,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q;

  // per evaluation: degree, point and power indices, parameter and its complement
  logic [IDX_W-1:0]   n_q, n_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [PARAM_W-1:0] t_q, t_d;
  logic [PARAM_W-1:0] u_q, u_d;

  // running powers and the partial results of one point
  logic [POW_W-1:0] pw_q, pw_d;
  logic [POW_W-1:0] tpow_q, tpow_d;
  logic [PLO_W-1:0] plo_q, plo_d;
  logic [POW_W-1:0] prod_q, prod_d;
  logic [POW_W-1:0] w_q, w_d;

  logic signed [ACC_W-1:0] accx_q, accx_d;
  logic signed [ACC_W-1:0] accy_q, accy_d;

  // (1-t)^k table and control point table, neither is reset
  logic [POW_W-1:0]        upow_q [MAX_POINTS];
  logic [2*COORD_BITS-1:0] pts_q  [MAX_POINTS];

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_x_d;
  logic signed [COORD_BITS-1:0] out_y_q, out_y_d;

  logic                         in_fire;
  logic                         eval_fire;
  logic                         load_fire;
  logic                         out_free;
  logic [CNT_W-1:0]             cnt_eff;
  logic [CNT_W-1:0]             cnt_m1;
  logic [PARAM_W-1:0]           t_sat;
  logic [IDX_W-1:0]             up_idx;
  logic [POW_W-1:0]             upow_rd;
  logic [2*COORD_BITS-1:0]      pts_rd;
  logic signed [COORD_BITS-1:0] px_rd;
  logic signed [COORD_BITS-1:0] py_rd;
  logic [COMB_W-1:0]            comb;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [HSUM_W-1:0]         hsum;

  // request handshake
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign eval_fire   = in_fire && (in_if.cmd == CMD_EVAL);
  assign load_fire   = in_fire && (in_if.cmd == CMD_LOAD);
  assign out_free    = !out_valid_q || out_if.ready;

  // counts beyond the table use the whole table
  assign cnt_eff = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
  assign cnt_m1  = cnt_eff - CNT_W'(1);

  // t above one is clamped to one
  assign t_sat = (in_if.curve_param > ONE_Q16) ? ONE_Q16 : in_if.curve_param;

  // point i pairs with (1-t)^(n-i)
  assign up_idx  = n_q - i_q;
  assign upow_rd = upow_q[up_idx];
  assign pts_rd  = pts_q[i_q];
  assign px_rd   = signed'(pts_rd[2*COORD_BITS-1:COORD_BITS]);
  assign py_rd   = signed'(pts_rd[COORD_BITS-1:0]);
  assign comb    = BINOM[n_q][i_q];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_POW: begin
        mul_a = MUL_A_W'(pw_q);
        mul_b = MUL_B_W'(u_q);
      end
      ST_MLO: begin
        mul_a = MUL_A_W'(tpow_q);
        mul_b = MUL_B_W'(upow_rd[FRAC16-1:0]);
      end
      ST_MHI: begin
        mul_a = MUL_A_W'(tpow_q);
        mul_b = MUL_B_W'(upow_rd[POW_W-1:FRAC16]);
      end
      ST_MW: begin
        mul_a = MUL_A_W'(prod_q);
        mul_b = MUL_B_W'(comb);
      end
      ST_MX: begin
        mul_a = MUL_A_W'(w_q);
        mul_b = MUL_B_W'(px_rd);
      end
      ST_MY: begin
        mul_a = MUL_A_W'(w_q);
        mul_b = MUL_B_W'(py_rd);
      end
      ST_MT: begin
        mul_a = MUL_A_W'(tpow_q);
        mul_b = MUL_B_W'(t_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // high half of t^i * (1-t)^(n-i), with the low partial product shifted in
  assign hsum = HSUM_W'(mul_p[PLO_W-1:0]) + HSUM_W'(plo_q[PLO_W-1:FRAC16]);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_fire) begin
          if (cnt_eff == '0) begin
            state_d = ST_FIN;
          end else if (cnt_eff == CNT_W'(1)) begin
            state_d = ST_MLO;
          end else begin
            state_d = ST_POW;
          end
        end
      end
      ST_POW: begin
        if (k_q == n_q) begin
          state_d = ST_MLO;
        end
      end
      ST_MLO: state_d = ST_MHI;
      ST_MHI: state_d = ST_MW;
      ST_MW:  state_d = ST_MX;
      ST_MX:  state_d = ST_MY;
      ST_MY: begin
        if (i_q == n_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MT;
        end
      end
      ST_MT:  state_d = ST_MLO;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates per state
  always_comb begin
    n_d    = n_q;
    i_d    = i_q;
    k_d    = k_q;
    t_d    = t_q;
    u_d    = u_q;
    pw_d   = pw_q;
    tpow_d = tpow_q;
    plo_d  = plo_q;
    prod_d = prod_q;
    w_d    = w_q;
    accx_d = accx_q;
    accy_d = accy_q;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_fire) begin
          t_d    = t_sat;
          u_d    = ONE_Q16 - t_sat;
          n_d    = cnt_m1[IDX_W-1:0];
          i_d    = '0;
          k_d    = IDX_W'(1);
          pw_d   = ONE_Q32;
          tpow_d = ONE_Q32;
          accx_d = '0;
          accy_d = '0;
        end
      end
      ST_POW: begin
        pw_d = mul_p[POW_W+FRAC16-1:FRAC16];
        k_d  = k_q + IDX_W'(1);
      end
      ST_MLO: plo_d  = mul_p[PLO_W-1:0];
      ST_MHI: prod_d = hsum[POW_W+FRAC16-1:FRAC16];
      // a single weight never exceeds 2^32
      ST_MW:  w_d    = mul_p[POW_W-1:0];
      ST_MX:  accx_d = accx_q + signed'(mul_p[ACC_W-1:0]);
      ST_MY:  accy_d = accy_q + signed'(mul_p[ACC_W-1:0]);
      ST_MT: begin
        tpow_d = mul_p[POW_W+FRAC16-1:FRAC16];
        i_d    = i_q + IDX_W'(1);
      end
      ST_FIN: begin
        n_d = n_q;
      end
      default: begin
        n_d = n_q;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_if.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
      out_x_d     = finish_coord(accx_q);
      out_y_d     = finish_coord(accy_q);
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.curve_x = out_x_q;
  assign out_if.curve_y = out_y_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    k_q     <= k_d;
    t_q     <= t_d;
    u_q     <= u_d;
    pw_q    <= pw_d;
    tpow_q  <= tpow_d;
    plo_q   <= plo_d;
    prod_q  <= prod_d;
    w_q     <= w_d;
    accx_q  <= accx_d;
    accy_q  <= accy_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

  // power table: entry 0 is one, entry k filled by the k-th power step
  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      upow_q[0] <= ONE_Q32;
    end else if (state_q == ST_POW) begin
      upow_q[k_q] <= pw_d;
    end
  end

  // control point table, x in the upper half
  always_ff @(posedge clk_i) begin
    if (load_fire && (int'(in_if.point_index) < MAX_POINTS)) begin
      pts_q[IDX_W'(in_if.point_index)] <= {in_if.point_x, in_if.point_y};
    end
  end

endmodule

/* sim/bcpe_curve_point_check.sv */
`timescale 1ns / 1ps
// monitor, predictor and comparator for the bezier point evaluator channels
// depends on bcpe_pkg and the channel interfaces in bcpe_if.sv

module bcpe_curve_point_check
  import bcpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bcpe_in_if               req_mon,
  bcpe_out_if              res_mon,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;
  localparam longint unsigned Q16_ONE = 64'h1_0000;
  localparam int              REPORT_MAX = 10;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } curve_pt_t;

  logic signed [COORD_BITS-1:0] ctrl_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ctrl_y [MAX_POINTS];
  logic [CNT_W-1:0]             num_points;
  curve_pt_t                    expected_pts [$];
  int                           mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_pts.size();

  // drop 32 fraction bits toward zero and clamp to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] trunc_sat(input longint s);
    longint hi;
    longint q;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    if (s < 0) begin
      q = -longint'(longint'(-s) >>> 32);
    end else begin
      q = s >>> 32;
    end
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return q[COORD_BITS-1:0];
  endfunction

  // bernstein sum with q0.32 powers, each power step floored
  function automatic curve_pt_t eval_curve_point(input logic [PARAM_W-1:0] t_raw);
    longint unsigned upow [MAX_POINTS];
    longint unsigned tpow [MAX_POINTS];
    longint unsigned t;
    longint unsigned u;
    longint unsigned comb;
    longint unsigned a;
    longint unsigned b;
    longint unsigned prod;
    longint          w;
    longint          sx;
    longint          sy;
    int              cnt;
    int              deg;
    curve_pt_t       pt;
    cnt = (num_points > MAX_POINTS) ? MAX_POINTS : int'(num_points);
    if (cnt == 0) begin
      return '0;
    end
    deg = cnt - 1;
    t = (t_raw > Q16_ONE) ? Q16_ONE : longint'(t_raw);
    u = Q16_ONE - t;
    upow[0] = Q32_ONE;
    tpow[0] = Q32_ONE;
    for (int i = 1; i <= deg; i++) begin
      upow[i] = (upow[i-1] * u) >> 16;
      tpow[i] = (tpow[i-1] * t) >> 16;
    end
    comb = 1;
    sx = 0;
    sy = 0;
    for (int i = 0; i <= deg; i++) begin
      a = upow[deg-i];
      b = tpow[i];
      prod = (a >= Q32_ONE) ? b : ((a * b) >> 32);
      w = longint'(comb * prod);
      sx += w * longint'(ctrl_x[i]);
      sy += w * longint'(ctrl_y[i]);
      comb = comb * longint'(deg - i) / longint'(i + 1);
    end
    pt.x = trunc_sat(sx);
    pt.y = trunc_sat(sy);
    return pt;
  endfunction

  initial begin
    mismatches = 0;
    num_points = '0;
  end

  always @(posedge clk_i) begin
    curve_pt_t want;
    if (!rst_ni) begin
      num_points = '0;
      expected_pts.delete();
    end else begin
      if (cfg_we_i) begin
        num_points = cfg_wdata_i;
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.cmd == CMD_LOAD) begin
          ctrl_x[req_mon.point_index] = req_mon.point_x;
          ctrl_y[req_mon.point_index] = req_mon.point_y;
        end else begin
          expected_pts.push_back(eval_curve_point(req_mon.curve_param));
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_pts.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected curve point (%0d,%0d)", res_mon.curve_x, res_mon.curve_y);
          end
          mismatches++;
        end else begin
          want = expected_pts.pop_front();
          if (res_mon.curve_x !== want.x || res_mon.curve_y !== want.y) begin
            if (mismatches < REPORT_MAX) begin
              $display("curve point differs: expected (%0d,%0d) got (%0d,%0d)",
                       want.x, want.y, res_mon.curve_x, res_mon.curve_y);
            end
            mismatches++;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_bezier_curve_point_eval.sv */
`timescale 1ns / 1ps
// top of the bezier point evaluator testbench: clock, reset, stimulus, verdict
// depends on bcpe_pkg, bcpe_if.sv, the block and bcpe_curve_point_check

module tb_bezier_curve_point_eval;
  import bcpe_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  // drain wait, longer than the longest evaluation
  localparam int DRAIN_CYCLES = 120;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  int               fail_count;
  int               pending_cnt;

  // sender pacing state
  int               burst_left;
  int               items_sent;

  // receiver stall pattern
  logic [15:0]      stall_pat;

  bcpe_in_if  req_ch ();
  bcpe_out_if res_ch ();

  bezier_curve_point_eval uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (req_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bcpe_curve_point_check curve_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(64'd20_000_000);
    $display("bezier_curve_point_eval: mismatch");
    $finish;
  end

  // coordinates: extremes, zero and small values get a fair share, the rest is uniform
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return '0;
      3:       return COORD_BITS'($urandom_range(0, 15)) - 16'sd8;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // t: ends of the curve, values above one (saturated) and the range from zero to one
  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return PARAM_W'($urandom_range(65537, 131071));
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // idle the request channel, n sets how long
  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
  endtask

  // one request, sent in bursts with random gaps between them
  task automatic send_req(input cmd_e c, input logic [PIDX_W-1:0] idx,
                          input logic signed [COORD_BITS-1:0] x,
                          input logic signed [COORD_BITS-1:0] y,
                          input logic [PARAM_W-1:0] t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      // about a third of the bursts follow straight on
      if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 30));
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.point_index <= idx;
    req_ch.point_x     <= x;
    req_ch.point_y     <= y;
    req_ch.curve_param <= t;
    // ready only rises while the sequencer is idle
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // load request; the parameter field carries noise
  task automatic load_point(input int slot, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
    send_req(CMD_LOAD, PIDX_W'(slot), x, y, PARAM_W'($urandom));
  endtask

  // eval request; index and coordinates carry noise
  task automatic eval_at(input logic [PARAM_W-1:0] t);
    send_req(CMD_EVAL, PIDX_W'($urandom), rand_coord(), rand_coord(), t);
  endtask

  // point_count only changes once the block has drained and gone idle
  task automatic set_point_count(input int cnt);
    pause(1);
    wait (pending_cnt == 0);
    pause(DRAIN_CYCLES);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(cnt);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver: each random 16-bit stall pattern is played four times in a row
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom);
        2:       stall_pat = 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: stall_pat = 16'hFF00;
      endcase
      for (int k = 0; k < 64; k++) begin
        @(negedge clk_i);
        res_ch.ready <= stall_pat[k % 16];
      end
    end
  end

  initial begin
    int cnt;
    int used;
    int first_slot;
    // every input known from time zero
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_LOAD;
    req_ch.point_index = '0;
    req_ch.point_x     = '0;
    req_ch.point_y     = '0;
    req_ch.curve_param = '0;
    burst_left         = 0;
    items_sent         = 0;

    // reset held low at the start, released on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero count answers the origin without reading the table
    set_point_count(0);
    eval_at('0);
    eval_at(ONE_Q16);

    // fill every slot before any eval reads the table, extremes first
    load_point(0, 16'sh7FFF, -16'sh8000);
    load_point(1, -16'sh8000, 16'sh7FFF);
    load_point(2, 16'sh7FFF, 16'sh7FFF);
    load_point(3, -16'sh8000, -16'sh8000);
    for (int s = 4; s < MAX_POINTS; s++) begin
      load_point(s, rand_coord(), rand_coord());
    end

    // single point: the curve is that point for any t
    set_point_count(1);
    eval_at(PARAM_W'(32768));

    // full degree: both ends, the middle, the smallest step and t above one
    set_point_count(MAX_POINTS);
    eval_at('0);
    eval_at(ONE_Q16);
    eval_at(PARAM_W'(32768));
    eval_at(PARAM_W'(1));
    eval_at({PARAM_W{1'b1}});

    // count above the table size behaves as a full table
    set_point_count(31);
    eval_at(PARAM_W'(49152));

    // random phases: one point_count each, mostly well-formed load-then-eval runs
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       cnt = 0;
        1:       cnt = MAX_POINTS;
        2:       cnt = $urandom_range(MAX_POINTS + 1, 31);
        3, 4, 5: cnt = $urandom_range(1, 4);
        default: cnt = $urandom_range(1, MAX_POINTS);
      endcase
      set_point_count(cnt);
      used = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any command with any fields
          repeat ($urandom_range(1, 6)) begin
            send_req(cmd_e'($urandom_range(0, 1)), PIDX_W'($urandom),
                     COORD_BITS'($urandom), COORD_BITS'($urandom), PARAM_W'($urandom));
          end
        end else begin
          // reload part or all of the active points, then walk the curve
          first_slot = (used == 0) ? 0 : $urandom_range(0, used - 1);
          for (int s = first_slot; s < used; s++) begin
            load_point(s, rand_coord(), rand_coord());
          end
          repeat ($urandom_range(1, 10)) eval_at(rand_param());
        end
      end
    end

    // drain: every expected point in, then the drain wait for strays
    pause(1);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bezier_curve_point_eval: match");
    end else begin
      $display("bezier_curve_point_eval: mismatch");
    end
    $finish;
  end

endmodule

/* bezier_curve_point_eval.f */
sv/bcpe_pkg.sv
sv/bcpe_if.sv
sv/bezier_curve_point_eval.sv
sim/bcpe_curve_point_check.sv
sim/tb_bezier_curve_point_eval.sv
